// ===== rtl/core/qbf_pkg.sv =====
// Shared types, constants and helpers of the quadratic Bezier flattener.
package qbf_pkg;

   localparam int COORD_W       = 24;
   localparam int COLOR_W       = 8;
   localparam int LEVEL_W       = 3;
   localparam int TOL_W         = 32;
   localparam int CSR_DATA_W    = 32;
   localparam int CSR_INDEX_W   = 1;
   localparam int DEFAULT_DEPTH = 6;
   localparam logic [TOL_W-1:0] TOL_RESET = 32'd16384;

   // Second difference 2*c - s - e and its square.
   localparam int DIFF_W = COORD_W + 2;
   localparam int SQ_W   = 2 * DIFF_W - 1;
   localparam int SUM_W  = SQ_W + 1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TOLERANCE  = 1'b0,
      CSR_EMIT_COLOR = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_DECIDE
   } state_type;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } point_type;

   typedef struct packed {
      point_type          p0;
      point_type          p1;
      point_type          p2;
      logic [LEVEL_W-1:0] level;
   } stack_entry_type;

   typedef struct packed {
      logic load;
      logic square;
      logic split;
      logic emit;
      logic pop;
   } cmd_type;

   typedef struct packed {
      logic leaf;
      logic stack_empty;
      logic out_free;
   } status_type;

   // Midpoint of two coordinates, rounded toward minus infinity.
   function automatic coord_type half_sum(coord_type a, coord_type b);
      logic signed [COORD_W:0] s;
      s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
      return s[COORD_W:1];
   endfunction

endpackage

// ===== rtl/core/qbf_intf.sv =====
// Channel interfaces of the flattener: curve input, segment output, register writes.
interface qbf_req_if;
   logic                        valid;
   logic                        ready;
   logic signed [23:0]          start_x;
   logic signed [23:0]          start_y;
   logic signed [23:0]          ctrl_x;
   logic signed [23:0]          ctrl_y;
   logic signed [23:0]          end_x;
   logic signed [23:0]          end_y;
   logic [7:0]                  curve_color;

   modport source (output valid, start_x, start_y, ctrl_x, ctrl_y, end_x, end_y,
                   curve_color, input ready);
   modport sink   (input valid, start_x, start_y, ctrl_x, ctrl_y, end_x, end_y,
                   curve_color, output ready);
endinterface

interface qbf_rsp_if;
   logic                        valid;
   logic                        ready;
   logic signed [23:0]          seg_start_x;
   logic signed [23:0]          seg_start_y;
   logic signed [23:0]          seg_end_x;
   logic signed [23:0]          seg_end_y;
   logic [7:0]                  seg_color;
   logic                        color_valid;
   logic                        last_segment;

   modport source (output valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
                   seg_color, color_valid, last_segment, input ready);
   modport sink   (input valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
                   seg_color, color_valid, last_segment, output ready);
endinterface

interface qbf_csr_if;
   logic                        valid;
   logic                        ready;
   logic [0:0]                  index;
   logic [31:0]                 data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/qbf_ctrl.sv =====
// Sequencer of the flattener: walks the subdivision tree one node at a time.
module qbf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  qbf_pkg::status_type status,
   output qbf_pkg::cmd_type    cmd
);
   import qbf_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (!status.leaf) begin
               cmd.split = 1'b1;
               state_in  = ST_SQUARE;
            end else if (status.out_free) begin
               // A leaf goes out as a chord; the stack then supplies the next piece.
               cmd.emit = 1'b1;
               if (status.stack_empty) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.pop  = 1'b1;
                  state_in = ST_SQUARE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/core/qbf_datapath.sv =====
// Datapath of the flattener: current piece, pending stack, flatness test, output word.
module qbf_datapath #(
   parameter int MAX_DEPTH = qbf_pkg::DEFAULT_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   qbf_req_if.sink             req_ch,
   qbf_rsp_if.source           rsp_ch,
   qbf_csr_if.sink             csr_ch,
   input  qbf_pkg::cmd_type    cmd,
   output qbf_pkg::status_type status
);
   import qbf_pkg::*;

   localparam int TOP_W = $clog2(MAX_DEPTH + 1);
   localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

   // Configuration registers.
   logic [TOL_W-1:0] tol_ff;
   logic             emit_color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff        <= TOL_RESET;
         emit_color_ff <= 1'b0;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_TOLERANCE:  tol_ff        <= csr_ch.data[TOL_W-1:0];
            CSR_EMIT_COLOR: emit_color_ff <= csr_ch.data[0];
            default: ;
         endcase
      end
   end

   assign csr_ch.ready = 1'b1;

   // Current piece and pending right halves.
   point_type          p0_ff, p1_ff, p2_ff;
   logic [LEVEL_W-1:0] level_ff;
   logic [TOP_W-1:0]   top_ff;
   logic [COLOR_W-1:0] color_ff;
   stack_entry_type    stack_ff [MAX_DEPTH];

   logic [TOP_W-1:0]   top_dec;
   stack_entry_type    pop_entry_ff;
   point_type          q0, q1, r;

   assign top_dec = top_ff - TOP_W'(1);

   // The entry under the top is fetched every cycle; a pop always follows a square cycle,
   // so the fetched entry is current by the time it is used.
   always_ff @(posedge clock) begin
      pop_entry_ff <= stack_ff[top_dec[IDX_W-1:0]];
   end

   always_comb begin
      q0.x = half_sum(p0_ff.x, p1_ff.x);
      q0.y = half_sum(p0_ff.y, p1_ff.y);
      q1.x = half_sum(p1_ff.x, p2_ff.x);
      q1.y = half_sum(p1_ff.y, p2_ff.y);
      r.x  = half_sum(q0.x, q1.x);
      r.y  = half_sum(q0.y, q1.y);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         p0_ff    <= '{x: req_ch.start_x, y: req_ch.start_y};
         p1_ff    <= '{x: req_ch.ctrl_x, y: req_ch.ctrl_y};
         p2_ff    <= '{x: req_ch.end_x, y: req_ch.end_y};
         color_ff <= req_ch.curve_color;
      end else if (cmd.split) begin
         p1_ff <= q0;
         p2_ff <= r;
      end else if (cmd.pop) begin
         p0_ff <= pop_entry_ff.p0;
         p1_ff <= pop_entry_ff.p1;
         p2_ff <= pop_entry_ff.p2;
      end
      if (cmd.split) begin
         stack_ff[top_ff[IDX_W-1:0]] <= '{p0: r, p1: q1, p2: p2_ff,
                                          level: level_ff + LEVEL_W'(1)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
         top_ff   <= '0;
      end else if (cmd.load) begin
         level_ff <= '0;
         top_ff   <= '0;
      end else if (cmd.split) begin
         level_ff <= level_ff + LEVEL_W'(1);
         top_ff   <= top_ff + TOP_W'(1);
      end else if (cmd.pop) begin
         level_ff <= pop_entry_ff.level;
         top_ff   <= top_dec;
      end
   end

   // Flatness test: squares are registered; the sum and compare are combinational on the registers.
   logic signed [DIFF_W-1:0]   dx, dy;
   logic signed [2*DIFF_W-1:0] dx_sq, dy_sq;
   logic [SQ_W-1:0]            sq_x_ff, sq_y_ff;
   logic [SUM_W-1:0]           sq_sum, tol_scaled;
   logic                       flat, at_limit;

   assign dx    = {p1_ff.x[COORD_W-1], p1_ff.x, 1'b0}
                - {{2{p0_ff.x[COORD_W-1]}}, p0_ff.x}
                - {{2{p2_ff.x[COORD_W-1]}}, p2_ff.x};
   assign dy    = {p1_ff.y[COORD_W-1], p1_ff.y, 1'b0}
                - {{2{p0_ff.y[COORD_W-1]}}, p0_ff.y}
                - {{2{p2_ff.y[COORD_W-1]}}, p2_ff.y};
   assign dx_sq = dx * dx;
   assign dy_sq = dy * dy;

   always_ff @(posedge clock) begin
      if (cmd.square) begin
         sq_x_ff <= dx_sq[SQ_W-1:0];
         sq_y_ff <= dy_sq[SQ_W-1:0];
      end
   end

   // The distance is d/4, so the test against the tolerance is sum <= 16 * tol.
   assign sq_sum     = {1'b0, sq_x_ff} + {1'b0, sq_y_ff};
   assign tol_scaled = SUM_W'({tol_ff, 4'b0000});
   assign flat       = sq_sum <= tol_scaled;
   assign at_limit   = level_ff >= LEVEL_W'(MAX_DEPTH);

   // Output word register.
   logic               rsp_valid_ff;
   point_type          seg_start_ff, seg_end_ff;
   logic [COLOR_W-1:0] seg_color_ff;
   logic               color_valid_ff;
   logic               last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         seg_start_ff   <= p0_ff;
         seg_end_ff     <= p2_ff;
         seg_color_ff   <= emit_color_ff ? color_ff : '0;
         color_valid_ff <= emit_color_ff;
         last_ff        <= (top_ff == '0);
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.seg_start_x  = seg_start_ff.x;
   assign rsp_ch.seg_start_y  = seg_start_ff.y;
   assign rsp_ch.seg_end_x    = seg_end_ff.x;
   assign rsp_ch.seg_end_y    = seg_end_ff.y;
   assign rsp_ch.seg_color    = seg_color_ff;
   assign rsp_ch.color_valid  = color_valid_ff;
   assign rsp_ch.last_segment = last_ff;

   assign status.leaf        = flat || at_limit;
   assign status.stack_empty = (top_ff == '0);
   assign status.out_free    = !rsp_valid_ff || rsp_ch.ready;

endmodule

// ===== rtl/core/quad_bezier_flattener.sv =====
// Quadratic Bezier flattener, top level: sequencer plus datapath.
// Each accepted curve is split depth-first by de Casteljau halving and every
// flat piece (or every piece at depth MAX_DEPTH) comes out as one chord word,
// in curve order, the final one marked last_segment. A curve is accepted in the
// idle state; then each node of its subdivision tree has a square step for
// the second differences and a decide step to compare and split or emit;
// with MAX_DEPTH = 6 that is at most 127 nodes. An emit waits while the
// output register holds a word that is not taken. The next curve is accepted
// as soon as the last chord of the previous one sits in the output register.
// Register writes take effect in the next cycle and belong between curves.
module quad_bezier_flattener #(
   parameter int MAX_DEPTH = qbf_pkg::DEFAULT_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   qbf_req_if.sink   req_ch,
   qbf_rsp_if.source rsp_ch,
   qbf_csr_if.sink   csr_ch
);
   import qbf_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       ctrl_req_ready;

   qbf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (ctrl_req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   qbf_datapath #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch),
      .cmd    (cmd),
      .status (status)
   );

   assign req_ch.ready = ctrl_req_ready;

endmodule

// ===== rtl/core/qbf_checker.sv =====
// Port-level checks of the flattener and their binding to the top level.
module qbf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_seg_color,
   input logic       rsp_color_valid
);

   // A word that is not taken stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("output word withdrawn before it was taken");

   // Once a curve is taken the block is busy with it in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("new curve accepted right after the previous one");

   // The first chord of a curve cannot appear in the cycle after acceptance.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("chord appeared too early after a curve was accepted");

   // With color output off the color tag is zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_color_valid |-> rsp_seg_color == 8'd0)
      else $error("color tag set while color output is off");

endmodule

bind quad_bezier_flattener qbf_checker u_qbf_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_seg_color   (rsp_ch.seg_color),
   .rsp_color_valid (rsp_ch.color_valid)
);

// ===== tb/quad_bezier_flattener_test.sv =====
// Self-checking testbench of the quadratic Bezier flattener with a built-in chord predictor.
`timescale 1ns / 1ps

module quad_bezier_flattener_test;
   import qbf_pkg::*;

   localparam int          DEPTH_LIMIT    = DEFAULT_DEPTH;
   localparam int          STACK_SLOTS    = 6;
   localparam int          MAX_SEGS       = 64;
   localparam longint unsigned SQ_SUM_MAX = 64'hFF_FFFF_FFFF;
   localparam int          LONG_HOLD      = 300;
   localparam int          WATCHDOG_LIMIT = 2000;
   localparam int          SETTLE_CYCLES  = 6;
   localparam coord_type   MAXC           = 24'sh7FFFFF;
   localparam coord_type   MINC           = -24'sh800000;

   typedef struct {
      coord_type          start_x, start_y, ctrl_x, ctrl_y, end_x, end_y;
      logic [COLOR_W-1:0] curve_color;
   } curve_word_type;

   typedef struct {
      coord_type          seg_start_x, seg_start_y, seg_end_x, seg_end_y;
      logic [COLOR_W-1:0] seg_color;
      logic               color_valid;
      logic               last_segment;
   } segment_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   qbf_req_if req_ch ();
   qbf_rsp_if rsp_ch ();
   qbf_csr_if csr_ch ();

   quad_bezier_flattener DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   curve_word_type   curves_todo[$];
   segment_word_type segs_due[$];

   // Register copies used by the predictor, updated when a write is accepted.
   logic [TOL_W-1:0] tol_cfg   = TOL_RESET;
   logic             color_cfg = 1'b0;

   bit  curve_taken = 1'b0;
   bit  seg_taken   = 1'b0;
   bit  no_idle     = 1'b0;
   bit  long_hold_req    = 1'b0;
   bit  long_hold_served = 1'b0;
   bit  timed_out   = 1'b0;
   int  mismatches  = 0;
   int  idle_cycles = 0;
   int  send_gap    = 0;
   int  recv_stall  = 0;
   int  recv_draw   = 0;
   int  hold_left   = 0;
   curve_word_type next_curve;
   curve_word_type taken_curve;

   function automatic point_type midpoint_down(input point_type a, input point_type b);
      point_type m;
      m.x = coord_type'((longint'(a.x) + longint'(b.x)) >>> 1);
      m.y = coord_type'((longint'(a.y) + longint'(b.y)) >>> 1);
      return m;
   endfunction

   function automatic bit curve_is_flat(input point_type p[3]);
      longint          dx, dy;
      longint unsigned sum;
      dx = 2 * longint'(p[1].x) - longint'(p[0].x) - longint'(p[2].x);
      dy = 2 * longint'(p[1].y) - longint'(p[0].y) - longint'(p[2].y);
      sum = dx * dx + dy * dy;
      if (sum > SQ_SUM_MAX) sum = SQ_SUM_MAX;
      return sum <= (longint'(tol_cfg) << 4);
   endfunction

   // Depth-first de Casteljau split; every flat piece or piece at the depth limit becomes one expected chord.
   function automatic void flatten_curve(input curve_word_type c);
      point_type        pts[3];
      point_type        pend[STACK_SLOTS][3];
      int unsigned      pend_lvl[STACK_SLOTS];
      int unsigned      lvl, top, nseg;
      point_type        q0, q1, mid;
      segment_word_type s;
      bit               done;
      pts[0].x = c.start_x;
      pts[0].y = c.start_y;
      pts[1].x = c.ctrl_x;
      pts[1].y = c.ctrl_y;
      pts[2].x = c.end_x;
      pts[2].y = c.end_y;
      lvl  = 0;
      top  = 0;
      nseg = 0;
      done = 1'b0;
      while (!done) begin
         if (lvl >= DEPTH_LIMIT || top >= STACK_SLOTS || curve_is_flat(pts)) begin
            s.seg_start_x  = pts[0].x;
            s.seg_start_y  = pts[0].y;
            s.seg_end_x    = pts[2].x;
            s.seg_end_y    = pts[2].y;
            s.seg_color    = color_cfg ? c.curve_color : '0;
            s.color_valid  = color_cfg;
            s.last_segment = (top == 0) || (nseg + 1 >= MAX_SEGS);
            segs_due.push_back(s);
            nseg++;
            if (s.last_segment) begin
               done = 1'b1;
            end else begin
               top--;
               for (int i = 0; i < 3; i++) pts[i] = pend[top][i];
               lvl = pend_lvl[top];
            end
         end else begin
            q0  = midpoint_down(pts[0], pts[1]);
            q1  = midpoint_down(pts[1], pts[2]);
            mid = midpoint_down(q0, q1);
            pend[top][0] = mid;
            pend[top][1] = q1;
            pend[top][2] = pts[2];
            pend_lvl[top] = lvl + 1;
            top++;
            pts[1] = q0;
            pts[2] = mid;
            lvl++;
         end
      end
   endfunction

   function automatic void check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   function automatic curve_word_type make_curve(input coord_type sx, input coord_type sy,
                                                 input coord_type cx, input coord_type cy,
                                                 input coord_type ex, input coord_type ey,
                                                 input logic [COLOR_W-1:0] color);
      curve_word_type c;
      c.start_x = sx;
      c.start_y = sy;
      c.ctrl_x  = cx;
      c.ctrl_y  = cy;
      c.end_x   = ex;
      c.end_y   = ey;
      c.curve_color = color;
      return c;
   endfunction

   function automatic coord_type near(input coord_type base, input int unsigned span);
      longint v;
      v = longint'(base) + longint'($urandom_range(2 * span, 0)) - longint'(span);
      if (v > longint'(MAXC)) v = longint'(MAXC);
      if (v < longint'(MINC)) v = longint'(MINC);
      return coord_type'(v);
   endfunction

   function automatic coord_type pick_extreme();
      case ($urandom_range(3, 0))
         0: return MINC;
         1: return MAXC;
         2: return '0;
         default: return -24'sd1;
      endcase
   endfunction

   // Mostly local curves of a few sizes, plus full-range, degenerate, straight and corner cases.
   function automatic curve_word_type random_curve();
      curve_word_type c;
      coord_type      bx, by;
      int unsigned    span;
      int unsigned    kind;
      kind = $urandom_range(9, 0);
      bx = coord_type'($urandom);
      by = coord_type'($urandom);
      case (kind)
         0, 1, 2, 3, 4, 5: begin
            span = (kind < 3) ? 64 : (kind < 5) ? 2048 : 65536;
            c = make_curve(near(bx, span), near(by, span), near(bx, span), near(by, span),
                           near(bx, span), near(by, span), '0);
         end
         6: begin
            c = make_curve(coord_type'($urandom), coord_type'($urandom),
                           coord_type'($urandom), coord_type'($urandom),
                           coord_type'($urandom), coord_type'($urandom), '0);
         end
         7: begin
            c = make_curve(bx, by, bx, by, bx, by, '0);
         end
         8: begin
            c = make_curve(near(bx, 4096), near(by, 4096), bx, by,
                           near(bx, 4096), near(by, 4096), '0);
            c.ctrl_x = coord_type'((longint'(c.start_x) + longint'(c.end_x)) >>> 1);
            c.ctrl_y = coord_type'((longint'(c.start_y) + longint'(c.end_y)) >>> 1);
         end
         default: begin
            c = make_curve(pick_extreme(), pick_extreme(), pick_extreme(),
                           pick_extreme(), pick_extreme(), pick_extreme(), '0);
         end
      endcase
      c.curve_color = COLOR_W'($urandom_range(255, 0));
      return c;
   endfunction

   // Curve driver.
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || curve_taken) begin
         if (send_gap > 0) begin
            req_ch.valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (curves_todo.size() > 0) begin
            next_curve = curves_todo.pop_front();
            req_ch.start_x     <= next_curve.start_x;
            req_ch.start_y     <= next_curve.start_y;
            req_ch.ctrl_x      <= next_curve.ctrl_x;
            req_ch.ctrl_y      <= next_curve.ctrl_y;
            req_ch.end_x       <= next_curve.end_x;
            req_ch.end_y       <= next_curve.end_y;
            req_ch.curve_color <= next_curve.curve_color;
            req_ch.valid       <= 1'b1;
            send_gap <= no_idle ? 0 : $urandom_range(4, 0);
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Segment receiver: a short random stall (or none) after each word, one long hold when asked.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (long_hold_req && !long_hold_served) begin
         long_hold_served <= 1'b1;
         hold_left <= LONG_HOLD;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (seg_taken) begin
         recv_draw = no_idle ? 0 : $urandom_range(4, 0);
         rsp_ch.ready <= (recv_draw == 0);
         recv_stall <= (recv_draw > 0) ? recv_draw - 1 : 0;
      end else if (recv_stall > 0) begin
         recv_stall <= recv_stall - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Monitor: checks segment words, predicts on accepted curves, runs the watchdog.
   always @(posedge clock) begin
      curve_taken <= !reset && req_ch.valid && req_ch.ready;
      seg_taken   <= !reset && rsp_ch.valid && rsp_ch.ready;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (segs_due.size() == 0) begin
            $error("segment word with no expectation: start (%0d,%0d) end (%0d,%0d)",
                   rsp_ch.seg_start_x, rsp_ch.seg_start_y, rsp_ch.seg_end_x, rsp_ch.seg_end_y);
            mismatches++;
         end else begin
            automatic segment_word_type want = segs_due.pop_front();
            check_field("seg_start_x", want.seg_start_x, rsp_ch.seg_start_x);
            check_field("seg_start_y", want.seg_start_y, rsp_ch.seg_start_y);
            check_field("seg_end_x", want.seg_end_x, rsp_ch.seg_end_x);
            check_field("seg_end_y", want.seg_end_y, rsp_ch.seg_end_y);
            check_field("seg_color", want.seg_color, rsp_ch.seg_color);
            check_field("color_valid", want.color_valid, rsp_ch.color_valid);
            check_field("last_segment", want.last_segment, rsp_ch.last_segment);
         end
      end
      if (!reset && req_ch.valid && req_ch.ready) begin
         taken_curve.start_x     = req_ch.start_x;
         taken_curve.start_y     = req_ch.start_y;
         taken_curve.ctrl_x      = req_ch.ctrl_x;
         taken_curve.ctrl_y      = req_ch.ctrl_y;
         taken_curve.end_x       = req_ch.end_x;
         taken_curve.end_y       = req_ch.end_y;
         taken_curve.curve_color = req_ch.curve_color;
         flatten_curve(taken_curve);
      end
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         timed_out <= 1'b1;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      wait (timed_out);
      $display("[quad_bezier_flattener] ERROR");
      $finish;
   end

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      csr_ch.valid <= 1'b1;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      case (idx)
         CSR_TOLERANCE:  tol_cfg   = value;
         CSR_EMIT_COLOR: color_cfg = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // The test waits until every queued curve is sent and every expected word has been taken.
   task automatic wait_drained();
      @(negedge clock);
      while (curves_todo.size() != 0 || req_ch.valid || segs_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic queue_random(input int count);
      for (int i = 0; i < count; i++) curves_todo.push_back(random_curve());
   endtask

   initial begin
      csr_ch.valid      = 1'b0;
      csr_ch.index      = CSR_TOLERANCE;
      csr_ch.data       = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset settings: quarter-pixel tolerance, color off.
      curves_todo.push_back(make_curve(0, 0, 0, 0, 0, 0, 8'h00));
      curves_todo.push_back(make_curve(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, 8'hFF));
      curves_todo.push_back(make_curve(MINC, MINC, MINC, MINC, MINC, MINC, 8'h3C));
      curves_todo.push_back(make_curve(MINC, MINC, -1, -1, MAXC, MAXC, 8'hC3));
      curves_todo.push_back(make_curve(MINC, MINC, MAXC, MAXC, MINC, MINC, 8'h81));
      curves_todo.push_back(make_curve(MAXC, MINC, MINC, MAXC, MAXC, MINC, 8'hA5));
      // The first of these two sits exactly on the tolerance, the second just above it.
      curves_todo.push_back(make_curve(0, 0, 256, 256, 512, 0, 8'h11));
      curves_todo.push_back(make_curve(0, 0, 256, 257, 512, 0, 8'h22));
      curves_todo.push_back(make_curve(MINC, MAXC, 0, 0, MAXC, MINC, 8'h7E));
      curves_todo.push_back(make_curve(-3, -5, -8, 7, 1, -1, 8'h5A));
      wait_drained();

      // Zero tolerance, color on: only perfectly straight pieces count as flat.
      write_reg(CSR_TOLERANCE, '0);
      write_reg(CSR_EMIT_COLOR, 32'd1);
      curves_todo.push_back(make_curve(-3, -5, -8, 7, 1, -1, 8'hFF));
      curves_todo.push_back(make_curve(100, -100, 101, -100, 102, -100, 8'h00));
      curves_todo.push_back(make_curve(0, 0, 1, 0, 0, 0, 8'h5A));
      curves_todo.push_back(make_curve(MAXC, MINC, MAXC, MINC, MAXC, MINC, 8'h80));
      curves_todo.push_back(make_curve(MINC, 0, MAXC, MAXC, MAXC, MINC, 8'h01));
      wait_drained();

      write_reg(CSR_TOLERANCE, 32'hFFFF_FFFF);
      curves_todo.push_back(make_curve(MINC, MINC, MAXC, MAXC, MINC, MINC, 8'hA5));
      curves_todo.push_back(make_curve(0, 0, 1000, 1000, 2000, 0, 8'h5A));
      queue_random(28);
      wait_drained();

      // The receiver holds off while curves keep coming, so the input backs up.
      write_reg(CSR_TOLERANCE, TOL_RESET);
      long_hold_req = 1'b1;
      queue_random(30);
      wait_drained();

      write_reg(CSR_TOLERANCE, $urandom);
      write_reg(CSR_EMIT_COLOR, '0);
      no_idle = 1'b1;
      queue_random(25);
      wait_drained();

      no_idle = 1'b0;
      write_reg(CSR_TOLERANCE, $urandom_range(32'h0010_0000, 0));
      write_reg(CSR_EMIT_COLOR, 32'd1);
      queue_random(25);
      wait_drained();

      repeat (20) @(posedge clock);
      if (mismatches == 0 && segs_due.size() == 0) begin
         $display("[quad_bezier_flattener] OK");
      end else begin
         $display("[quad_bezier_flattener] ERROR");
      end
      $finish;
   end

endmodule
